>>> design/assert_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// prop must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)

`endif

`endif

>>> design/mexp_pkg.sv
// Package for the modular exponentiation unit: types, constants, states.
package mexp_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int FIELD_W   = 32;

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] power_mod;
    logic               zero_modulus;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } state_t;

  // controls of the shared shift/add/reduce step
  typedef struct packed {
    logic cin;
    logic add_en;
  } step_ctl_t;

endpackage

>>> design/mexp_modstep.sv
// Shared modular step: r' = ((2r + cin) mod m + (add_en ? a : 0)) mod m.
module mexp_modstep #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic [WIDTH-1:0]  r,
  input  logic [WIDTH-1:0]  a,
  input  logic [WIDTH-1:0]  m,
  input  mexp_pkg::step_ctl_t ctl,
  output logic [WIDTH-1:0]  res
);
  import mexp_pkg::*;

  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   m_ext;
  logic [WIDTH-1:0] t;
  logic [WIDTH:0]   s;

  assign m_ext = {1'b0, m};
  assign dbl   = {r, ctl.cin};

  always_comb begin
    if (dbl >= m_ext) begin
      t = WIDTH'(dbl - m_ext);
    end else begin
      t = WIDTH'(dbl);
    end
    s = {1'b0, t} + (ctl.add_en ? {1'b0, a} : '0);
    if (s >= m_ext) begin
      res = WIDTH'(s - m_ext);
    end else begin
      res = WIDTH'(s);
    end
  end

endmodule

>>> design/modular_exponentiation_unit.sv
// Top level: right-to-left binary modular exponentiation on one shared modular step.
//
//  channel | ports                         | payload
//  --------+-------------------------------+----------------------------------
//  input   | in_valid, in_ready, in_data   | base, exponent, modulus
//  result  | out_valid, out_ready, out_data| power_mod, zero_modulus
//
// Base reduction runs first on the single shift/add/reduce step, then every modular multiply
// or square runs on the same step, one multiplier bit per cycle.
// A zero modulus or zero exponent skips the step and goes straight from idle to FIN.
// in_ready is high only when idle; a result waits in FIN while the previous one is unaccepted.
// Reset (rst_n, synchronous) returns to idle and drops out_valid.
`include "assert_macros.svh"

module modular_exponentiation_unit #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mexp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mexp_pkg::out_t out_data
);
  import mexp_pkg::*;

  localparam int CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(WIDTH - 1);

  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] e_r, e_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [WIDTH-1:0] sreg_r, sreg_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             zm_r, zm_nxt;
  out_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  step_ctl_t        ctl;
  logic [WIDTH-1:0] step_a;
  logic [WIDTH-1:0] step_res;
  logic             last;
  logic [WIDTH-1:0] in_b, in_e, in_m;
  logic [WIDTH-1:0] e_shr;

  assign in_b  = WIDTH'(in_data.base);
  assign in_e  = WIDTH'(in_data.exponent);
  assign in_m  = WIDTH'(in_data.modulus);
  assign e_shr = e_r >> 1;
  assign last  = (cnt_r == CntLast);

  assign ctl.cin    = (state_r == ST_REDUCE) & sreg_r[WIDTH-1];
  assign ctl.add_en = (state_r != ST_REDUCE) & sreg_r[WIDTH-1];
  assign step_a     = (state_r == ST_MUL) ? acc_r : b_r;

  mexp_modstep #(.WIDTH(WIDTH)) u_step (
    .r   (r_r),
    .a   (step_a),
    .m   (m_r),
    .ctl (ctl),
    .res (step_res)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    e_r    <= e_nxt;
    m_r    <= m_nxt;
    sreg_r <= sreg_nxt;
    r_r    <= r_nxt;
    zm_r   <= zm_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    sreg_nxt      = sreg_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    zm_nxt        = zm_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          m_nxt    = in_m;
          e_nxt    = in_e;
          zm_nxt   = (in_m == '0);
          acc_nxt  = WIDTH'(1);
          sreg_nxt = in_b;
          r_nxt    = '0;
          cnt_nxt  = '0;
          if (in_m == '0) begin
            acc_nxt   = '0;
            state_nxt = ST_FIN;
          end else if (in_e == '0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE, ST_MUL, ST_SQR: begin
        r_nxt    = step_res;
        sreg_nxt = sreg_r << 1;
        cnt_nxt  = cnt_r + CntW'(1);
        if (last) begin
          cnt_nxt = '0;
          r_nxt   = '0;
          if (state_r == ST_REDUCE) begin
            b_nxt     = step_res;
            sreg_nxt  = step_res;
            state_nxt = e_r[0] ? ST_MUL : ST_SQR;
          end else if (state_r == ST_MUL) begin
            acc_nxt   = step_res;
            sreg_nxt  = b_r;
            state_nxt = (e_shr == '0) ? ST_FIN : ST_SQR;
          end else begin
            b_nxt     = step_res;
            e_nxt     = e_shr;
            sreg_nxt  = step_res;
            state_nxt = e_shr[0] ? ST_MUL : ST_SQR;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.power_mod    = FIELD_W'(acc_r);
          out_nxt.zero_modulus = zm_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `ASSERT_PROP(a_partial_reduced, clk, rst_n,
    (state_r == ST_REDUCE || state_r == ST_MUL || state_r == ST_SQR) |-> (r_r < m_r),
    "partial result not below modulus")
  `ASSERT_PROP(a_base_reduced, clk, rst_n,
    (state_r == ST_MUL || state_r == ST_SQR) |-> (b_r < m_r),
    "working base not below modulus")
  `ASSERT_NEVER(a_exp_live, clk, rst_n,
    (state_r == ST_MUL || state_r == ST_SQR) && (e_r == '0),
    "multiply or square with exhausted exponent")
  `ASSERT_PROP(a_zero_mod_result, clk, rst_n,
    (state_r == ST_FIN && zm_r) |-> (acc_r == '0),
    "zero modulus must give zero result")

endmodule

>>> tb/tb_modular_exponentiation_unit.sv
// Testbench for modular_exponentiation_unit: directed and random requests vs a power-mod model.
`timescale 1ns / 1ps

module tb_modular_exponentiation_unit;
  import mexp_pkg::*;

  localparam int NUM_RANDOM   = 250;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 2100;
  localparam int HOLD_CYCLES  = 3000;
  localparam int CYCLE_LIMIT  = 2_000_000;

  typedef struct {
    in_t  req;
    out_t res;
  } power_entry_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t          pending_requests[$];
  power_entry_t expected_powers[$];
  int           mismatch_count = 0;
  int           results_seen   = 0;
  int           cycle_count    = 0;
  int           burst_left     = 0;
  int           gap_left       = 0;
  int           rx_cycle       = 0;
  int           hold_left      = 0;
  int           holds_taken    = 0;
  rx_mode_t     rx_mode        = RX_OPEN;
  power_entry_t head;
  power_entry_t issued;

  modular_exponentiation_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic out_t predict_power_mod(in_t req);
    out_t        res;
    bit [63:0]   sq;
    bit [63:0]   acc;
    bit [63:0]   m;
    bit [31:0]   e;
    res = '0;
    if (req.modulus == '0) begin
      res.zero_modulus = 1'b1;
      return res;
    end
    m   = 64'(req.modulus);
    sq  = 64'(req.base) % m;
    acc = 64'd1;
    e   = req.exponent;
    while (e != 0) begin
      if (e[0])
        acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      e  = e >> 1;
    end
    res.power_mod = acc[31:0];
    return res;
  endfunction

  function automatic in_t random_request();
    in_t         req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      req.modulus = '0;
    else if (pick < 6)
      req.modulus = 32'd1;
    else if (pick < 20)
      req.modulus = $urandom_range(2, 1000);
    else if (pick < 45)
      req.modulus = $urandom | 32'h8000_0000;
    else
      req.modulus = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 4)
      req.exponent = '0;
    else if (pick < 35)
      req.exponent = $urandom & ((32'd1 << $urandom_range(1, 10)) - 32'd1);
    else if (pick < 40)
      req.exponent = 32'hFFFF_FFFF;
    else
      req.exponent = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 4)
      req.base = '0;
    else if (pick < 8)
      req.base = 32'hFFFF_FFFF;
    else if (pick < 15)
      req.base = $urandom_range(0, 15);
    else
      req.base = $urandom;
    return req;
  endfunction

  task automatic queue_request(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    in_t req;
    req.base     = b;
    req.exponent = e;
    req.modulus  = m;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // driver: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        issued = '{req: in_data, res: predict_power_mod(in_data)};
        expected_powers.insert(expected_powers.size(), issued);
      end
      if (in_valid && !in_ready) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_requests.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern, plus two long hold-offs to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 600 == 0)
        rx_mode = rx_mode_t'($urandom_range(0, 2));
      if (holds_taken < 2 && results_seen >= 20 + 100 * holds_taken) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= (rx_cycle % 7) < 4;
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_powers.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: power_mod=%h zero_modulus=%b",
                   out_data.power_mod, out_data.zero_modulus);
        mismatch_count++;
      end else begin
        head = expected_powers.pop_front();
        if (out_data.power_mod !== head.res.power_mod ||
            out_data.zero_modulus !== head.res.zero_modulus) begin
          if (mismatch_count < 10)
            $display("mismatch: base=%h exponent=%h modulus=%h expected %h/%b got %h/%b",
                     head.req.base, head.req.exponent, head.req.modulus,
                     head.res.power_mod, head.res.zero_modulus,
                     out_data.power_mod, out_data.zero_modulus);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    queue_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(32'h1234_5678, 32'h0000_0001, 32'h0000_0000);
    queue_request(32'h0000_0005, 32'h0000_0000, 32'h0000_0001);
    queue_request(32'h0001_2345, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(32'h0000_0007, 32'h0000_0003, 32'h0000_0001);
    queue_request(32'h0000_0000, 32'h0000_0005, 32'h0000_000D);
    queue_request(32'h0000_0000, 32'h0000_0000, 32'h0000_000D);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(32'h0000_0004, 32'h0000_000D, 32'h0000_01F1);
    queue_request(32'h0000_0002, 32'h0000_001F, 32'h8000_0000);
    queue_request(32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
    queue_request(32'h0000_0064, 32'h0000_0001, 32'h0000_0007);
    queue_request(32'h0000_000D, 32'h0000_0001, 32'h0000_000D);
    queue_request(32'h0000_0002, 32'h8000_0000, 32'h0100_0003);
    queue_request(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
    queue_request(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAB);
    queue_request(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002);
    queue_request($urandom, 32'h0000_0002, 32'hFFFF_FFFF);
    for (int i = 0; i < NUM_RANDOM; i++)
      pending_requests.insert(pending_requests.size(), random_request());

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_powers.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_powers.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
